### src/pewe_pkg.sv
`default_nettype none

package pewe_pkg;

	// Register map: register i sits at byte address 8*i.
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned AddrW   = 6;
	localparam int unsigned DataW   = 64;

	typedef enum logic [RegIdxW-1:0] {
		REG_FORMAT         = 3'd0,
		REG_CLIP_THRESHOLD = 3'd1,
		REG_ROUND_ENABLE   = 3'd2,
		REG_PALETTE_LOW    = 3'd3,
		REG_PALETTE_HIGH   = 3'd4,
		REG_SIDECAR_BASE   = 3'd5
	} reg_idx_t;

	// Code formats. The spare code behaves like the six-bit format.
	typedef enum logic [1:0] {
		FMT_8BIT = 2'd0,
		FMT_4BIT = 2'd1,
		FMT_6BIT = 2'd2
	} fmt_t;

	localparam int unsigned PalMax  = 16;
	localparam int unsigned PalIdxW = 4;

	localparam logic [31:0] HashMul   = 32'd2654435761;
	localparam logic [31:0] RoundSeed = 32'h9E37_79B9;
	localparam logic [31:0] ClipSeed  = 32'd42;
	localparam logic [31:0] Bf16Bias  = 32'h0000_7FFF;

	// Marks an unused palette slot; larger than any real 8-bit distance.
	localparam logic [8:0] DistNone = 9'h100;

	function automatic logic [31:0] mix32(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

endpackage

`default_nettype wire

### src/palette_exponent_weight_encoder_core.sv
// Palette exponent weight encoder. A request (weight_bits, position) is taken at every rising
// edge where start is high; busy is tied low, so a new weight may be issued every cycle and
// the block sustains one weight per clock. Each request produces exactly one result,
// presented on code, exponent_distance, sidecar_flag, sidecar_index and sidecar_value
// for a single cycle with done high. The receiver cannot stall the block: a result that
// is not captured in that cycle is gone. The pipeline has five register stages: input
// capture, the 32-bit hash multiply, hashing plus clipping and stochastic rounding, the
// sixteen palette distances, and the minimum search that feeds the result register.
// Configuration goes through the APB port with 64-bit data, register i at byte address
// 8*i; write it only while no request is in flight.
`default_nettype none

module palette_exponent_weight_encoder_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Request side
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [31:0]                 weight_bits,
	input  wire logic [31:0]                 position,
	// Result side
	output logic                             done,
	output logic [7:0]                       code,
	output logic [7:0]                       exponent_distance,
	output logic                             sidecar_flag,
	output logic [31:0]                      sidecar_index,
	output logic [15:0]                      sidecar_value,
	// Configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pewe_pkg::AddrW-1:0]  paddr,
	input  wire logic [pewe_pkg::DataW-1:0]  pwdata,
	output logic [pewe_pkg::DataW-1:0]       prdata,
	output logic                             pready
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [1:0]  format_q;
	logic [7:0]  clip_threshold_q;
	logic        round_enable_q;
	logic [63:0] palette_low_q;
	logic [63:0] palette_high_q;
	logic [31:0] sidecar_base_q;

	logic                           cfg_wr;
	logic [pewe_pkg::RegIdxW-1:0]   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[pewe_pkg::AddrW-1:pewe_pkg::AddrW-pewe_pkg::RegIdxW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q         <= 2'd0;
			clip_threshold_q <= 8'd0;
			round_enable_q   <= 1'b1;
			palette_low_q    <= 64'd0;
			palette_high_q   <= 64'd0;
			sidecar_base_q   <= 32'd0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				pewe_pkg::REG_FORMAT:         format_q         <= pwdata[1:0];
				pewe_pkg::REG_CLIP_THRESHOLD: clip_threshold_q <= pwdata[7:0];
				pewe_pkg::REG_ROUND_ENABLE:   round_enable_q   <= pwdata[0];
				pewe_pkg::REG_PALETTE_LOW:    palette_low_q    <= pwdata;
				pewe_pkg::REG_PALETTE_HIGH:   palette_high_q   <= pwdata;
				pewe_pkg::REG_SIDECAR_BASE:   sidecar_base_q   <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pewe_pkg::REG_FORMAT:         prdata = {62'd0, format_q};
			pewe_pkg::REG_CLIP_THRESHOLD: prdata = {56'd0, clip_threshold_q};
			pewe_pkg::REG_ROUND_ENABLE:   prdata = {63'd0, round_enable_q};
			pewe_pkg::REG_PALETTE_LOW:    prdata = palette_low_q;
			pewe_pkg::REG_PALETTE_HIGH:   prdata = palette_high_q;
			pewe_pkg::REG_SIDECAR_BASE:   prdata = {32'd0, sidecar_base_q};
			default:                      prdata = 64'd0;
		endcase
	end

	// Format decode. The spare format code is handled as the six-bit format.
	// Masks and steps cover the mantissa bits that the code drops.
	logic [15:0] trunc_mask;
	logic [15:0] drop_step;
	logic [15:0] pal_used;

	always_comb begin
		case (format_q)
			pewe_pkg::FMT_8BIT: begin
				trunc_mask = 16'h000F;
				drop_step  = 16'h0010;
				pal_used   = 16'hFFFF;
			end
			pewe_pkg::FMT_4BIT: begin
				trunc_mask = 16'h003F;
				drop_step  = 16'h0040;
				pal_used   = 16'h000F;
			end
			default: begin
				trunc_mask = 16'h001F;
				drop_step  = 16'h0020;
				pal_used   = 16'h00FF;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: request capture. There is no back pressure, so a request
	// is accepted whenever start is high.
	// ------------------------------------------------------------------
	logic        accept;
	logic        valid_s1;
	logic [31:0] weight_s1;
	logic [31:0] position_s1;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			weight_s1   <= weight_bits;
			position_s1 <= position;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: hash multiply, BF16 round to nearest even, sidecar index.
	// ------------------------------------------------------------------
	logic        valid_s2;
	logic [31:0] prod_s2;
	logic [15:0] w_s2;
	logic [31:0] sidx_s2;
	logic [31:0] bf16_sum;

	assign bf16_sum = weight_s1 + pewe_pkg::Bf16Bias + {31'd0, weight_s1[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= position_s1 * pewe_pkg::HashMul;
			w_s2    <= bf16_sum[31:16];
			sidx_s2 <= sidecar_base_q + position_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: soft exponent clip, then stochastic rounding of the bits
	// that the code drops. The rounding add wraps at 16 bits, so a carry
	// may reach the exponent or the sign.
	// ------------------------------------------------------------------
	logic        valid_s3;
	logic [15:0] w_s3;
	logic [31:0] sidx_s3;

	logic [31:0] clip_hash;
	logic [31:0] round_hash;
	logic [8:0]  thr_p1;
	logic [7:0]  e_clip;
	logic [15:0] w_clip;
	logic [15:0] disc;
	logic [15:0] rnd_t;
	logic [15:0] w_trunc;
	logic [15:0] w_round;

	always_comb begin
		clip_hash  = pewe_pkg::mix32(prod_s2 + pewe_pkg::ClipSeed);
		round_hash = pewe_pkg::mix32(prod_s2 + pewe_pkg::RoundSeed);
		thr_p1     = {1'b0, clip_threshold_q} + 9'd1;
		e_clip     = w_s2[14:7];
		if (clip_threshold_q != 8'd0) begin
			if ({1'b0, w_s2[14:7]} > thr_p1) begin
				e_clip = clip_threshold_q;
			end else if ({1'b0, w_s2[14:7]} == thr_p1 && clip_hash[31]) begin
				e_clip = clip_threshold_q;
			end
		end
		w_clip  = {w_s2[15], e_clip, w_s2[6:0]};
		disc    = w_clip & trunc_mask;
		rnd_t   = round_hash[15:0] & trunc_mask;
		w_trunc = w_clip & ~trunc_mask;
		// With no dropped bits set, the truncated word equals the clipped one.
		if (!round_enable_q) begin
			w_round = w_clip;
		end else if (rnd_t < disc) begin
			w_round = w_trunc + drop_step;
		end else begin
			w_round = w_trunc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			w_s3    <= w_round;
			sidx_s3 <= sidx_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: distance from the final exponent to every palette entry.
	// Entries outside the active palette get a distance no real one reaches.
	// ------------------------------------------------------------------
	logic        valid_s4;
	logic [15:0] w_s4;
	logic [31:0] sidx_s4;
	logic [8:0]  dist_s4 [pewe_pkg::PalMax];
	logic [8:0]  dist_nx [pewe_pkg::PalMax];
	logic [7:0]  e_fin;

	always_comb begin
		logic [7:0] pent;
		pent  = 8'd0;
		e_fin = w_s3[14:7];
		for (int k = 0; k < pewe_pkg::PalMax; k++) begin
			if (k < 8) begin
				pent = palette_low_q[k*8 +: 8];
			end else begin
				pent = palette_high_q[(k-8)*8 +: 8];
			end
			if (!pal_used[k]) begin
				dist_nx[k] = pewe_pkg::DistNone;
			end else if (e_fin > pent) begin
				dist_nx[k] = {1'b0, e_fin - pent};
			end else begin
				dist_nx[k] = {1'b0, pent - e_fin};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			w_s4    <= w_s3;
			sidx_s4 <= sidx_s3;
			for (int k = 0; k < pewe_pkg::PalMax; k++) begin
				dist_s4[k] <= dist_nx[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: four-level minimum tree. The left (lower index) side wins
	// unless the right side is strictly closer, which gives the lowest
	// index on ties.
	// ------------------------------------------------------------------
	logic [8:0]                   l1_d [8];
	logic [pewe_pkg::PalIdxW-1:0] l1_i [8];
	logic [8:0]                   l2_d [4];
	logic [pewe_pkg::PalIdxW-1:0] l2_i [4];
	logic [8:0]                   l3_d [2];
	logic [pewe_pkg::PalIdxW-1:0] l3_i [2];
	logic [8:0]                   best_d;
	logic [pewe_pkg::PalIdxW-1:0] best_i;
	logic [7:0]                   code_nx;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (dist_s4[2*k+1] < dist_s4[2*k]) begin
				l1_d[k] = dist_s4[2*k+1];
				l1_i[k] = pewe_pkg::PalIdxW'(2*k+1);
			end else begin
				l1_d[k] = dist_s4[2*k];
				l1_i[k] = pewe_pkg::PalIdxW'(2*k);
			end
		end
		for (int k = 0; k < 4; k++) begin
			if (l1_d[2*k+1] < l1_d[2*k]) begin
				l2_d[k] = l1_d[2*k+1];
				l2_i[k] = l1_i[2*k+1];
			end else begin
				l2_d[k] = l1_d[2*k];
				l2_i[k] = l1_i[2*k];
			end
		end
		for (int k = 0; k < 2; k++) begin
			if (l2_d[2*k+1] < l2_d[2*k]) begin
				l3_d[k] = l2_d[2*k+1];
				l3_i[k] = l2_i[2*k+1];
			end else begin
				l3_d[k] = l2_d[2*k];
				l3_i[k] = l2_i[2*k];
			end
		end
		if (l3_d[1] < l3_d[0]) begin
			best_d = l3_d[1];
			best_i = l3_i[1];
		end else begin
			best_d = l3_d[0];
			best_i = l3_i[0];
		end
	end

	// Pack index, sign and kept mantissa bits for the active format.
	always_comb begin
		case (format_q)
			pewe_pkg::FMT_8BIT: code_nx = {best_i, w_s4[15], w_s4[6:4]};
			pewe_pkg::FMT_4BIT: code_nx = {4'd0, best_i[1:0], w_s4[15], w_s4[6]};
			default:            code_nx = {2'd0, best_i[2:0], w_s4[15], w_s4[6:5]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4) begin
			code              <= code_nx;
			exponent_distance <= best_d[7:0];
			sidecar_flag      <= (best_d > 9'd1);
			sidecar_index     <= sidx_s4;
			sidecar_value     <= w_s4;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("accepted request did not produce its result strobe in time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && !valid_s2 && !valid_s3 && !valid_s4 |=> !done)
		else $error("result strobe with an empty pipeline");

	a_fmt4_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && format_q == pewe_pkg::FMT_4BIT |-> code[7:4] == 4'd0)
		else $error("four-bit code has bits above its width");

	a_fmt6_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && format_q != pewe_pkg::FMT_8BIT && format_q != pewe_pkg::FMT_4BIT
		|-> code[7:6] == 2'd0)
		else $error("six-bit code has bits above its width");

	a_flag_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> sidecar_flag == (exponent_distance > 8'd1))
		else $error("sidecar flag disagrees with distance");

endmodule

`default_nettype wire

### test/palette_exponent_weight_encoder_core_tb.sv
`default_nettype none

module palette_exponent_weight_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ClkHalf = 4;
	// Margin waited once every predicted result has come back.
	localparam int unsigned DrainCycles = 8;
	// Roughly 850 requests, the worst idle rate and the config phases fit many times over.
	localparam int unsigned CycleLimit = 200_000;
	localparam int unsigned MaxGap = 20;
	// The format register holds two bits; the spare code must act like the six-bit format.
	localparam logic [1:0] FmtSpare = 2'd3;

	// Directed palette: consecutive exponents around 1.0 in the low half, and the upper
	// half holds both ends of the exponent range plus entries that create ties.
	localparam logic [63:0] PalLowDirected  = 64'h8483_8281_807F_7E7D;
	localparam logic [63:0] PalHighDirected = 64'h0001_FEFF_9080_7F70;

	typedef struct packed {
		logic [7:0]  code;
		logic [7:0]  distance;
		logic        flag;
		logic [31:0] index;
		logic [15:0] value;
	} weight_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] weight_bits = '0;
	logic [31:0] position = '0;
	logic        done;
	logic [7:0]  code;
	logic [7:0]  exponent_distance;
	logic        sidecar_flag;
	logic [31:0] sidecar_index;
	logic [15:0] sidecar_value;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [pewe_pkg::AddrW-1:0] paddr = '0;
	logic [pewe_pkg::DataW-1:0] pwdata = '0;
	logic [pewe_pkg::DataW-1:0] prdata;
	logic        pready;

	// Our own copy of the register file, kept in step with every APB write.
	logic [1:0]  cfg_format = pewe_pkg::FMT_8BIT;
	logic [7:0]  cfg_clip = 8'd0;
	logic        cfg_round = 1'b1;
	logic [63:0] cfg_pal_lo = '0;
	logic [63:0] cfg_pal_hi = '0;
	logic [31:0] cfg_side_base = '0;

	// Encodings predicted for accepted requests, oldest first.
	weight_result_t pending_encodings[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	// Chance, in percent, that the sender leaves a given cycle empty.
	int unsigned idle_pct = 21;

	palette_exponent_weight_encoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.weight_bits(weight_bits),
		.position(position),
		.done(done),
		.code(code),
		.exponent_distance(exponent_distance),
		.sidecar_flag(sidecar_flag),
		.sidecar_index(sidecar_index),
		.sidecar_value(sidecar_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #ClkHalf clk = ~clk;

	// Xorshift scrambler that seeds both the clip coin flip and the rounding dither.
	function automatic logic [31:0] xorshift_mix(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	// Computes the full result for one weight under the current register settings:
	// BF16 conversion, soft exponent clip, stochastic rounding, then palette search.
	function automatic weight_result_t encode_weight(input logic [31:0] f,
			input logic [31:0] pos);
		logic [31:0] rounded, seed, h;
		logic [15:0] w, mask, disc, dither;
		logic [8:0]  clip_limit;
		logic [7:0]  e, entry;
		int unsigned drop, keep, pal_n, best_i, best_d, d, mant, sign_bit;
		weight_result_t r;
		case (cfg_format)
			pewe_pkg::FMT_8BIT: begin
				drop = 4; keep = 3; pal_n = 16;
			end
			pewe_pkg::FMT_4BIT: begin
				drop = 6; keep = 1; pal_n = 4;
			end
			default: begin
				drop = 5; keep = 2; pal_n = 8;
			end
		endcase

		// Round to nearest even on the raw bits; the 32-bit add may wrap to zero.
		rounded = f + pewe_pkg::Bf16Bias + {31'd0, f[16]};
		w = rounded[31:16];
		seed = pos * pewe_pkg::HashMul;

		// Exponents well above the threshold are clamped; the one just above it is
		// clamped on a coin flip taken from the top bit of the position hash.
		if (cfg_clip != 8'd0) begin
			e = w[14:7];
			clip_limit = {1'b0, cfg_clip} + 9'd1;
			h = xorshift_mix(seed + pewe_pkg::ClipSeed);
			if ({1'b0, e} > clip_limit)
				e = cfg_clip;
			else if ({1'b0, e} == clip_limit && h[31])
				e = cfg_clip;
			w[14:7] = e;
		end

		// Dropped mantissa bits round up when the dither falls below them. The carry
		// can run into the exponent and even the sign, since the add is 16 bits wide.
		if (cfg_round) begin
			mask = (16'd1 << drop) - 16'd1;
			disc = w & mask;
			if (disc != 16'd0) begin
				h = xorshift_mix(seed + pewe_pkg::RoundSeed);
				dither = h[15:0] & mask;
				w = w & ~mask;
				if (dither < disc)
					w = w + (16'd1 << drop);
			end
		end

		// Nearest palette exponent; strict less-than keeps the lowest index on ties.
		e = w[14:7];
		best_i = 0;
		best_d = 1000;
		for (int unsigned k = 0; k < pal_n; k++) begin
			entry = (k < 8) ? cfg_pal_lo[k*8 +: 8] : cfg_pal_hi[(k-8)*8 +: 8];
			d = (e > entry) ? 32'(e - entry) : 32'(entry - e);
			if (d < best_d) begin
				best_d = d;
				best_i = k;
			end
		end

		sign_bit = {31'd0, w[15]};
		mant = 32'(w >> (7 - keep)) & ((32'd1 << keep) - 32'd1);
		r.code = 8'((best_i << (keep + 1)) | (sign_bit << keep) | mant);
		r.distance = best_d[7:0];
		r.flag = (best_d > 1);
		r.index = cfg_side_base + pos;
		r.value = w;
		return r;
	endfunction

	// Every task below is entered just after a rising edge and returns just after one,
	// so each input gets at most one nonblocking update per falling edge.

	// Sends one request, with a random number of empty cycles in front of it.
	// Start is left high on return so back-to-back requests need no extra edge.
	task automatic send_weight(input logic [31:0] wbits, input logic [31:0] pos);
		int unsigned gap;
		gap = 0;
		while (gap < MaxGap && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		weight_bits <= wbits;
		position <= pos;
		do @(posedge clk); while (busy);
		pending_encodings.insert(pending_encodings.size(), encode_weight(wbits, pos));
	endtask

	// Stops issuing and waits until every predicted result has come back, then waits out
	// the DrainCycles margin so nothing can still be inside the pipeline.
	task automatic drain_pipeline();
		@(negedge clk);
		start <= 1'b0;
		while (pending_encodings.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// One APB write: setup cycle, access cycle, then the bus is released.
	task automatic write_register(input pewe_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			pewe_pkg::REG_FORMAT:         cfg_format = value[1:0];
			pewe_pkg::REG_CLIP_THRESHOLD: cfg_clip = value[7:0];
			pewe_pkg::REG_ROUND_ENABLE:   cfg_round = value[0];
			pewe_pkg::REG_PALETTE_LOW:    cfg_pal_lo = value;
			pewe_pkg::REG_PALETTE_HIGH:   cfg_pal_hi = value;
			pewe_pkg::REG_SIDECAR_BASE:   cfg_side_base = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Drains the core, then rewrites the whole register file.
	task automatic configure(input logic [1:0] fmt, input logic [7:0] clip,
			input logic rnd, input logic [63:0] pal_lo, input logic [63:0] pal_hi,
			input logic [31:0] base);
		drain_pipeline();
		write_register(pewe_pkg::REG_FORMAT, {62'd0, fmt});
		write_register(pewe_pkg::REG_CLIP_THRESHOLD, {56'd0, clip});
		write_register(pewe_pkg::REG_ROUND_ENABLE, {63'd0, rnd});
		write_register(pewe_pkg::REG_PALETTE_LOW, pal_lo);
		write_register(pewe_pkg::REG_PALETTE_HIGH, pal_hi);
		write_register(pewe_pkg::REG_SIDECAR_BASE, {32'd0, base});
	endtask

	// Register values straight out of reset: all-zero palette, rounding on, no clip.
	task automatic test_reset_defaults();
		send_weight(32'h3F80_0000, 32'h0000_0000);
		send_weight(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_weight(32'h0000_0000, 32'h1234_5678);
	endtask

	// All four format codes, including the spare one, with a wrapping sidecar base.
	// A negative weight with a full mantissa and an infinity hit both sign values.
	task automatic test_code_formats();
		logic [1:0] fmts[4];
		fmts = '{pewe_pkg::FMT_8BIT, pewe_pkg::FMT_4BIT, pewe_pkg::FMT_6BIT, FmtSpare};
		foreach (fmts[i]) begin
			configure(fmts[i], 8'd0, 1'b1, PalLowDirected, PalHighDirected, 32'hFFFF_FFF0);
			send_weight(32'hBF9F_FFFF, 32'hFFFF_FFFF);
			send_weight(32'h7F80_0000, 32'h0000_0000);
		end
	endtask

	// Threshold 127 with rounding off: exponents below, at, one above (several
	// positions, so the coin flip goes both ways) and far above the threshold.
	// Threshold 255 must leave even a NaN exponent alone.
	task automatic test_exponent_clipping();
		configure(pewe_pkg::FMT_8BIT, 8'd127, 1'b0, PalLowDirected, PalHighDirected, 32'd0);
		send_weight(32'h3F00_0000, 32'h0000_0000);
		send_weight(32'h3F80_0000, 32'h0000_0000);
		for (int unsigned p = 0; p < 4; p++)
			send_weight(32'h4000_0000, p);
		send_weight(32'h7F7F_0000, 32'h8000_0000);
		configure(pewe_pkg::FMT_8BIT, 8'd255, 1'b0, PalLowDirected, PalHighDirected, 32'd0);
		send_weight(32'h7FFF_0000, 32'h0000_0001);
		send_weight(32'hFF80_0000, 32'hFFFF_FFFF);
	endtask

	// Four-bit code drops the most bits. Covers no dropped bits, a full mantissa whose
	// carry reaches the exponent, the 16-bit wrap from 0xFFFF, and both rounding ties.
	task automatic test_stochastic_rounding();
		configure(pewe_pkg::FMT_4BIT, 8'd0, 1'b1, PalLowDirected, PalHighDirected, 32'd0);
		send_weight(32'h3F80_0000, 32'h0000_0007);
		send_weight(32'h3FFF_0000, 32'h0000_0000);
		send_weight(32'hFFFF_0000, 32'h0000_0003);
		send_weight(32'h3F80_8000, 32'h0000_0009);
		send_weight(32'h3F81_8000, 32'h0000_000A);
	endtask

	// Random requests at the given idle rate; the register file is redrawn every
	// 64 requests. Half the weights are shaped to land near the palette or the clip
	// threshold, a quarter set the top mantissa bits, the rest are raw bit patterns.
	task automatic test_random_traffic(input int unsigned pct, input int unsigned count);
		logic [1:0]  fmt;
		logic [7:0]  clip, exp8;
		logic        rnd, sign;
		logic [63:0] pal_lo, pal_hi;
		logic [31:0] base, wbits;
		logic [22:0] mant;
		idle_pct = pct;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 64 == 0) begin
				fmt = 2'($urandom_range(3));
				case ($urandom_range(3))
					0: clip = 8'd0;
					1: clip = 8'd255;
					2: clip = 8'($urandom_range(140, 112));
					default: clip = 8'($urandom());
				endcase
				rnd = 1'($urandom_range(1));
				if ($urandom_range(1)) begin
					pal_lo = {$urandom(), $urandom()};
					pal_hi = {$urandom(), $urandom()};
				end else begin
					// Clustered palette: duplicates and equidistant pairs give ties.
					for (int unsigned b = 0; b < 8; b++) begin
						pal_lo[b*8 +: 8] = 8'($urandom_range(142, 112));
						pal_hi[b*8 +: 8] = 8'($urandom_range(142, 112));
					end
				end
				case ($urandom_range(2))
					0: base = 32'd0;
					1: base = 32'hFFFF_FFFF;
					default: base = $urandom();
				endcase
				configure(fmt, clip, rnd, pal_lo, pal_hi, base);
			end
			sign = 1'($urandom_range(1));
			mant = 23'($urandom());
			case ($urandom_range(3))
				0: wbits = $urandom();
				1: begin
					exp8 = 8'($urandom_range(142, 112));
					wbits = {sign, exp8, mant};
				end
				2: begin
					// Exponent at or just above the clip threshold.
					exp8 = cfg_clip + 8'($urandom_range(2));
					wbits = {sign, exp8, mant};
				end
				default: begin
					// Top mantissa bits set, so rounding can carry into the exponent.
					exp8 = 8'($urandom());
					wbits = {sign, exp8, 7'h7F, mant[15:0]};
				end
			endcase
			send_weight(wbits, $urandom());
		end
	endtask

	// Result checker. Done is sampled at the rising edge; the receiver cannot stall,
	// so every strobe must match the oldest outstanding prediction.
	always @(posedge clk) begin : check_results
		weight_result_t want;
		if (arst_n && done) begin
			if (pending_encodings.size() == 0) begin
				$error("result with no request outstanding: code %0h, value %0h",
					code, sidecar_value);
				error_count++;
			end else begin
				want = pending_encodings.pop_front();
				if (code !== want.code) begin
					$error("code: expected %0h, got %0h", want.code, code);
					error_count++;
				end
				if (exponent_distance !== want.distance) begin
					$error("exponent_distance: expected %0d, got %0d", want.distance,
						exponent_distance);
					error_count++;
				end
				if (sidecar_flag !== want.flag) begin
					$error("sidecar_flag: expected %0b, got %0b", want.flag, sidecar_flag);
					error_count++;
				end
				if (sidecar_index !== want.index) begin
					$error("sidecar_index: expected %0h, got %0h", want.index,
						sidecar_index);
					error_count++;
				end
				if (sidecar_value !== want.value) begin
					$error("sidecar_value: expected %0h, got %0h", want.value,
						sidecar_value);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		// Reset is held from time zero and released on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_code_formats();
		test_exponent_clipping();
		test_stochastic_rounding();
		test_random_traffic(21, 267);
		test_random_traffic(79, 267);
		test_random_traffic(0, 267);
		drain_pipeline();

		// Leftover predictions cannot remain here: drain only returns once the
		// queue is empty, and the watchdog catches results that never arrive.
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
